FILE: hw/rtl/wmms_pkg.sv
// Shared constants and types for the windowed line statistics core.
// No dependencies.
package wmms_pkg;
	localparam int MAX_LINE   = 4096;
	localparam int FRAC_BITS  = 8;
	localparam int POS_W      = 13;
	localparam int SUM_W      = 29;
	localparam int SQ_W       = 42;
	localparam int V_W        = 56;  // N*S2 fits below 2^55
	localparam int Q_W        = 56;  // scaled quotient before the root
	localparam int ROOT_W     = 28;
	localparam int DIV_STEPS  = V_W + 2 * FRAC_BITS;
	localparam int CNT_W      = 7;
	localparam logic [0:0] REG_OFFSET = 1'b0;
	localparam logic [0:0] REG_SIZE   = 1'b1;

	typedef struct packed {
		logic signed [15:0] min_value;
		logic signed [15:0] max_value;
		logic signed [23:0] mean_q8;
		logic [23:0]        stdev_q8;
		logic [12:0]        sample_count;
		logic               empty_res;
	} result_t;

	typedef struct packed {
		logic signed [15:0] value;
		logic               last;
	} in_t;

	// controller -> datapath
	typedef struct packed {
		logic accum;     // take input item
		logic start;     // latch totals, begin products
		logic mul_step;  // one product stage
		logic div_init;
		logic div_step;
		logic sqrt_init;
		logic sqrt_step;
		logic finish;    // form result, clear line
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
	} sts_t;
endpackage

FILE: hw/rtl/wmms_if.sv
// Valid/ready stream interface carrying a payload of a chosen type.
// Depends on nothing but the type given at instantiation.
interface wmms_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: hw/rtl/wmms_datapath.sv
// Accumulators, product stages, restoring divider and bit-pair square root.
// Uses wmms_pkg.
module wmms_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  wmms_pkg::cmd_t             cmd,
	output wmms_pkg::sts_t             sts,
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_index,
	input  logic [12:0]                cfg_data,
	input  logic signed [15:0]         in_sample,
	output wmms_pkg::result_t          res
);
	logic [11:0] offset_q;
	logic [12:0] size_q;
	logic [12:0] pos_q, cnt_q;
	logic signed [wmms_pkg::SUM_W-1:0] sum_q;
	logic [wmms_pkg::SQ_W-1:0] sq_q;
	logic signed [15:0] min_q, max_q;
	logic in_win;
	logic [31:0] sq_in;
	logic [13:0] win_end;

	// end-of-line work registers
	logic [12:0] n_q;
	logic [27:0] abs_q;
	logic [wmms_pkg::SQ_W-1:0] s2_q;
	logic [1:0] ph_q;
	logic [wmms_pkg::V_W-1:0] a_q, b_q;
	logic [25:0] d_q;
	logic [wmms_pkg::V_W-1:0] v_q;
	logic [wmms_pkg::Q_W-1:0] q_q;
	logic [26:0] r_q;
	logic [wmms_pkg::ROOT_W-1:0] root_q;
	logic [wmms_pkg::Q_W+1:0] rem_q;
	logic [wmms_pkg::DIV_STEPS-1:0] mnum_q;
	logic [36:0] mq_q;
	logic [13:0] mr_q;
	logic mneg_q;
	logic [27:0] r_sh;
	logic [13:0] mr_sh;
	logic [wmms_pkg::Q_W+1:0] trial;

	assign win_end = {2'b0, offset_q} + {1'b0, size_q};
	assign in_win = (pos_q < 13'(wmms_pkg::MAX_LINE)) && (pos_q >= {1'b0, offset_q})
		&& ({1'b0, pos_q} < win_end);
	assign sq_in = 32'($signed(in_sample) * $signed(in_sample));
	assign sts.empty = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			size_q <= 13'd4096;
			pos_q <= '0;
			cnt_q <= '0;
			sum_q <= '0;
			sq_q <= '0;
			min_q <= 16'sh7fff;
			max_q <= -16'sh8000;
		end else begin
			if (cfg_we) begin
				if (cfg_index == wmms_pkg::REG_OFFSET) offset_q <= cfg_data[11:0];
				else size_q <= cfg_data;
			end
			if (cmd.accum) begin
				if (in_win) begin
					cnt_q <= cnt_q + 13'd1;
					sum_q <= sum_q + wmms_pkg::SUM_W'(in_sample);
					sq_q <= sq_q + wmms_pkg::SQ_W'(sq_in);
					if (in_sample < min_q) min_q <= in_sample;
					if (in_sample > max_q) max_q <= in_sample;
				end
				if (pos_q < 13'(wmms_pkg::MAX_LINE)) pos_q <= pos_q + 13'd1;
			end
			if (cmd.finish) begin
				pos_q <= '0;
				cnt_q <= '0;
				sum_q <= '0;
				sq_q <= '0;
				min_q <= 16'sh7fff;
				max_q <= -16'sh8000;
			end
		end
	end

	assign r_sh = {r_q, v_q[wmms_pkg::V_W-1]};
	assign mr_sh = {mr_q[12:0], mnum_q[wmms_pkg::DIV_STEPS-1]};
	assign trial = {root_q, 2'b01} & '1;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			n_q <= cnt_q;
			s2_q <= sq_q;
			abs_q <= 28'(sum_q < 0 ? -sum_q : sum_q);
			ph_q <= '0;
			mneg_q <= sum_q < 0;
			// numerator sits in the low bits so the quotient is complete after all steps
			mnum_q <= wmms_pkg::DIV_STEPS'(sum_q < 0 ? -sum_q : sum_q) << wmms_pkg::FRAC_BITS;
			mr_q <= '0;
		end
		if (cmd.mul_step) begin
			// one product per cycle, each under 32x32
			ph_q <= ph_q + 2'd1;
			unique case (ph_q)
				2'd0: a_q <= wmms_pkg::V_W'(n_q * s2_q[20:0]);
				2'd1: a_q <= a_q + (wmms_pkg::V_W'(n_q * s2_q[41:21]) << 21);
				2'd2: b_q <= wmms_pkg::V_W'(abs_q * abs_q);
				default: d_q <= 26'(n_q * n_q);
			endcase
		end
		if (cmd.div_init) begin
			v_q <= a_q > b_q ? a_q - b_q : '0;
			r_q <= '0;
			q_q <= '0;
		end
		if (cmd.div_step) begin
			// restoring divide of v*2^16 by d; v shifts out, zeros follow
			v_q <= v_q << 1;
			if ({1'b0, r_sh} >= {3'b0, d_q}) begin
				r_q <= 27'(r_sh - 28'(d_q));
				q_q <= {q_q[wmms_pkg::Q_W-2:0], 1'b1};
			end else begin
				r_q <= r_sh[26:0];
				q_q <= {q_q[wmms_pkg::Q_W-2:0], 1'b0};
			end
			// mean divide runs alongside on the same steps
			mnum_q <= mnum_q << 1;
			if (mr_sh >= {1'b0, n_q}) begin
				mr_q <= mr_sh - {1'b0, n_q};
				mq_q <= {mq_q[35:0], 1'b1};
			end else begin
				mr_q <= mr_sh;
				mq_q <= {mq_q[35:0], 1'b0};
			end
		end
		if (cmd.sqrt_init) begin
			root_q <= '0;
			rem_q <= '0;
		end
		if (cmd.sqrt_step) begin
			// two radicand bits per step, taken from the top of q
			q_q <= q_q << 2;
			if ({rem_q[wmms_pkg::Q_W-1:0], q_q[wmms_pkg::Q_W-1 -: 2]} >= trial) begin
				rem_q <= {rem_q[wmms_pkg::Q_W-1:0], q_q[wmms_pkg::Q_W-1 -: 2]} - trial;
				root_q <= {root_q[wmms_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[wmms_pkg::Q_W-1:0], q_q[wmms_pkg::Q_W-1 -: 2]};
				root_q <= {root_q[wmms_pkg::ROOT_W-2:0], 1'b0};
			end
		end
		if (cmd.finish) begin
			if (n_q == '0) begin
				res.min_value <= '0;
				res.max_value <= '0;
				res.mean_q8 <= '0;
				res.stdev_q8 <= '0;
				res.sample_count <= '0;
				res.empty_res <= 1'b1;
			end else begin
				res.min_value <= min_q;
				res.max_value <= max_q;
				res.mean_q8 <= mneg_q ? -24'(mq_q) : 24'(mq_q);
				res.stdev_q8 <= root_q[23:0];
				res.sample_count <= n_q;
				res.empty_res <= 1'b0;
			end
		end
	end
endmodule

FILE: hw/rtl/wmms_ctrl.sv
// Sequencer: accepts items, runs the end-of-line product, divide and root steps.
// Uses wmms_pkg.
module wmms_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_last,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  wmms_pkg::sts_t sts,
	output wmms_pkg::cmd_t cmd
);
	localparam logic [2:0] ST_RUN = 3'd0, ST_MUL = 3'd1, ST_DINIT = 3'd2, ST_DIV = 3'd3,
		ST_SINIT = 3'd4, ST_SQRT = 3'd5, ST_FIN = 3'd6;
	logic [2:0] state_q;
	logic [wmms_pkg::CNT_W-1:0] step_q;
	logic out_valid_q;
	logic take;

	assign out_valid = out_valid_q;
	assign in_ready = (state_q == ST_RUN);
	assign take = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		cmd.accum = take;
		// totals are latched once the last item has been added in
		cmd.start = (state_q == ST_MUL) && (step_q == '0);
		cmd.mul_step = (state_q == ST_MUL) && (step_q != '0);
		cmd.div_init = (state_q == ST_DINIT);
		cmd.div_step = (state_q == ST_DIV);
		cmd.sqrt_init = (state_q == ST_SINIT);
		cmd.sqrt_step = (state_q == ST_SQRT);
		cmd.finish = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_RUN: if (take && in_last) begin
					state_q <= ST_MUL;
					step_q <= '0;
				end
				ST_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == wmms_pkg::CNT_W'(4)) state_q <= sts.empty ? ST_FIN : ST_DINIT;
				end
				ST_DINIT: begin
					state_q <= ST_DIV;
					step_q <= '0;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == wmms_pkg::CNT_W'(wmms_pkg::DIV_STEPS - 1)) state_q <= ST_SINIT;
				end
				ST_SINIT: begin
					state_q <= ST_SQRT;
					step_q <= '0;
				end
				ST_SQRT: begin
					step_q <= step_q + 1'b1;
					if (step_q == wmms_pkg::CNT_W'(wmms_pkg::ROOT_W - 1)) state_q <= ST_FIN;
				end
				ST_FIN: if (cmd.finish) begin
					state_q <= ST_RUN;
					out_valid_q <= 1'b1;
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end
endmodule

FILE: hw/rtl/window_min_max_mean_stdev_core.sv
// Windowed line statistics core: one result item per line at the last sample.
// Instantiates wmms_ctrl and wmms_datapath; uses wmms_pkg and wmms_if.
//
// Samples are taken one per cycle while a line streams in. After the sample
// marked last the core stops accepting while it latches the totals, forms the
// products, sets up the divide, runs 72 restoring-divide steps (mean and
// variance quotient share them), sets up the root, runs 28 root steps and
// writes the output. An empty window skips the divide and root.
// The output cycle waits while the previous result item is still held.
// The result register holds one item while the next line starts.
module window_min_max_mean_stdev_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [12:0] cfg_data,
	wmms_if.sink        in_ch,
	wmms_if.source      out_ch
);
	wmms_pkg::cmd_t cmd;
	wmms_pkg::sts_t sts;

	wmms_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_last(in_ch.data.last), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts(sts), .cmd(cmd)
	);

	wmms_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_sample(in_ch.data.value), .res(out_ch.data)
	);
endmodule

FILE: hw/rtl/wmms_checker.sv
// Port-level checks for the statistics core, bound to the top level.
// Uses wmms_pkg.
module wmms_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              in_last,
	input logic              out_valid,
	input logic              out_ready,
	input wmms_pkg::result_t out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result dropped");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.empty_res |-> out_data.sample_count == '0) else $error("empty count");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.empty_res |-> out_data.sample_count != '0
		&& out_data.min_value <= out_data.max_value) else $error("bad stats");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready) else $error("accepted during compute");
endmodule

bind window_min_max_mean_stdev_core wmms_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_last(in_ch.data.last),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
